// ===== design/sfr_pkg.sv =====
`default_nettype none
package sfr_pkg;

  localparam int BYTE_W   = 8;
  localparam int CFG_W    = 64;
  localparam int LEN_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [CFG_W-1:0] pattern;
    logic [LEN_W-1:0] plen;
    logic [CFG_W-1:0] repl;
    logic [LEN_W-1:0] rlen;
  } sfr_cfg_t;

  typedef struct packed {
    logic load;
    logic byte_valid;
    logic last;
  } sfr_load_t;

endpackage
`default_nettype wire

// ===== design/stream_find_and_replace.sv =====
// The first result of a transaction passes the result queue and then the output register.
// Throughput: one input per cycle while each yields at most one result and out_ready is high;
// an input that yields more results holds the input while the single output port drains them.
// Reset: synchronous, active low; clears the pending count, the result queue and the
// configuration (pattern length 1, all else 0). The pending bytes are not cleared.
`default_nettype none
module stream_find_and_replace #(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_byte,
  output logic                               out_byte_valid,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfr_pkg::CFG_W-1:0]     cfg_data
);
  import sfr_pkg::*;

  localparam int QUEUE_DEPTH = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;

  sfr_cfg_t                      cfg;
  sfr_load_t                     ld;
  logic [LEN_W-1:0]              ld_cnt;
  logic [QUEUE_DEPTH*BYTE_W-1:0] ld_data;
  logic                          accept;

  assign accept = in_valid && in_ready;

  sfr_cfg #(
    .PATTERN_MAX (PATTERN_MAX),
    .REPLACE_MAX (REPLACE_MAX)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfr_step #(
    .PATTERN_MAX (PATTERN_MAX),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .cfg     (cfg),
    .ld      (ld),
    .ld_cnt  (ld_cnt),
    .ld_data (ld_data)
  );

  sfr_outq #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .ld             (ld),
    .ld_cnt         (ld_cnt),
    .ld_data        (ld_data),
    .load_ready     (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

// ===== design/sfr_cfg.sv =====
`default_nettype none
module sfr_cfg #(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sfr_pkg::CFG_W-1:0]     cfg_data,
  output sfr_pkg::sfr_cfg_t                  cfg
);
  import sfr_pkg::*;

  logic [CFG_W-1:0] pattern_r;
  logic [LEN_W-1:0] plen_r;
  logic [CFG_W-1:0] repl_r;
  logic [LEN_W-1:0] rlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      plen_r    <= LEN_W'(1);
      repl_r    <= '0;
      rlen_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PATTERN_BYTES:      pattern_r <= cfg_data;
        CFG_PATTERN_LENGTH:     plen_r    <= cfg_data[LEN_W-1:0];
        CFG_REPLACEMENT_BYTES:  repl_r    <= cfg_data;
        CFG_REPLACEMENT_LENGTH: rlen_r    <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A zero pattern length acts as one; both lengths saturate at their maximum.
  always_comb begin
    cfg.pattern = pattern_r;
    cfg.repl    = repl_r;
    if (plen_r == '0) begin
      cfg.plen = LEN_W'(1);
    end else if (plen_r > LEN_W'(PATTERN_MAX)) begin
      cfg.plen = LEN_W'(PATTERN_MAX);
    end else begin
      cfg.plen = plen_r;
    end
    if (rlen_r > LEN_W'(REPLACE_MAX)) begin
      cfg.rlen = LEN_W'(REPLACE_MAX);
    end else begin
      cfg.rlen = rlen_r;
    end
  end

endmodule
`default_nettype wire

// ===== design/sfr_step.sv =====
`default_nettype none
module sfr_step #(
  parameter int PATTERN_MAX = 8,
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              accept,
  input  wire logic [7:0]                        in_byte,
  input  wire logic                              in_last,
  input  wire sfr_pkg::sfr_cfg_t                 cfg,
  output sfr_pkg::sfr_load_t                     ld,
  output logic [sfr_pkg::LEN_W-1:0]              ld_cnt,
  output logic [QUEUE_DEPTH*sfr_pkg::BYTE_W-1:0] ld_data
);
  import sfr_pkg::*;

  logic [BYTE_W-1:0] win_r   [PATTERN_MAX];
  logic [BYTE_W-1:0] win_nxt [PATTERN_MAX];
  logic [BYTE_W-1:0] wn      [PATTERN_MAX];
  logic [LEN_W-1:0]  cnt_r;
  logic [LEN_W-1:0]  cnt_nxt;
  logic [LEN_W-1:0]  pos;
  logic [LEN_W-1:0]  c1;
  logic [LEN_W-1:0]  drop;
  logic [LEN_W-1:0]  emit;
  logic              match;
  logic              hit;

  always_comb begin
    pos = (cnt_r >= LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX - 1) : cnt_r;
    c1  = pos + LEN_W'(1);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      wn[i] = (LEN_W'(i) == pos) ? in_byte : win_r[i];
    end

    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LEN_W'(i) < cfg.plen && wn[i] != cfg.pattern[BYTE_W*i +: BYTE_W]) begin
        match = 1'b0;
      end
    end
    hit = (c1 == cfg.plen) && match;

    if (c1 > cfg.plen) begin
      drop = c1 - cfg.plen;
    end else if (c1 == cfg.plen && !hit) begin
      drop = LEN_W'(1);
    end else begin
      drop = '0;
    end

    if (hit) begin
      emit = cfg.rlen;
    end else if (in_last) begin
      emit = c1;
    end else begin
      emit = drop;
    end

    ld_data = '0;
    if (hit) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ld_data[BYTE_W*i +: BYTE_W] = cfg.repl[BYTE_W*i +: BYTE_W];
      end
    end else begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        ld_data[BYTE_W*i +: BYTE_W] = wn[i];
      end
    end

    ld.last       = in_last;
    ld.byte_valid = 1'b1;
    ld_cnt        = emit;
    if (emit == '0) begin
      // A final transaction that yields no byte leaves a bare end marker.
      ld.byte_valid = 1'b0;
      ld_cnt        = LEN_W'(1);
      ld_data[BYTE_W-1:0] = '0;
    end
    ld.load = accept && (emit != '0 || in_last);

    for (int i = 0; i < PATTERN_MAX; i++) begin
      win_nxt[i] = win_r[i];
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (LEN_W'(j) == LEN_W'(i) + drop) begin
          win_nxt[i] = wn[j];
        end
      end
    end
    cnt_nxt = (hit || in_last) ? '0 : c1 - drop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/sfr_outq.sv =====
`default_nettype none
module sfr_outq #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sfr_pkg::sfr_load_t                ld,
  input  wire logic [sfr_pkg::LEN_W-1:0]         ld_cnt,
  input  wire logic [QUEUE_DEPTH*sfr_pkg::BYTE_W-1:0] ld_data,
  output logic                                   load_ready,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             out_byte,
  output logic                                   out_byte_valid,
  output logic                                   out_last
);
  import sfr_pkg::*;

  logic [QUEUE_DEPTH*BYTE_W-1:0] q_data_r;
  logic [LEN_W-1:0]              q_cnt_r;
  logic                          q_bv_r;
  logic                          q_last_r;
  logic                          out_valid_r;
  logic [BYTE_W-1:0]             out_byte_r;
  logic                          out_bv_r;
  logic                          out_last_r;
  logic                          pop;

  assign pop        = (q_cnt_r != '0) && (!out_valid_r || out_ready);
  assign load_ready = (q_cnt_r == '0) || (q_cnt_r == LEN_W'(1) && pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld.load) begin
        q_cnt_r <= ld_cnt;
      end else if (pop) begin
        q_cnt_r <= q_cnt_r - LEN_W'(1);
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      q_data_r <= ld_data;
      q_bv_r   <= ld.byte_valid;
      q_last_r <= ld.last;
    end else if (pop) begin
      q_data_r <= q_data_r >> BYTE_W;
    end
    if (pop) begin
      out_byte_r <= q_data_r[BYTE_W-1:0];
      out_bv_r   <= q_bv_r;
      out_last_r <= q_last_r && (q_cnt_r == LEN_W'(1));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_byte_valid = out_bv_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire
